@@ src/bfba_pkg.sv @@
// Shared types and constants of the Bloom filter bit array.
// Used by every module of the block; depends on nothing.

package bfba_pkg;

    localparam int HASH_PORTS   = 8;
    localparam int PORT_HASH_W  = 32;
    localparam int CFG_BITS_W   = 17;
    localparam int CFG_HASH_W   = 4;
    localparam int ONES_W       = 17;
    localparam int WORD_W       = 32;
    localparam int WORD_SEL_W   = 5;
    localparam int HSEL_W       = 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic REG_BIT_COUNT  = 1'b0;
    localparam logic REG_HASH_COUNT = 1'b1;

    typedef logic [PORT_HASH_W-1:0] hash_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MOD,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } seq_state_t;

endpackage

@@ src/bloom_filter_bit_array.sv @@
// Bloom filter bit array: a command port takes add, check and clear words with
// eight hash values each; one result word comes back per command.
//
// Usage: hold start high with func and hash_0..hash_7; the word is taken at the
// clock edge where start is high and busy is low. The hash ports are captured
// then and may change afterwards. The result appears on present and ones_total
// for exactly one cycle, marked by done; the receiver cannot stall it.
// Add and check handle the effective hash count of hashes in turn (a check ends
// early at the first clear cell). Each hash needs a start and one pass of the
// shared bit-serial modulo unit (one hash bit per cycle), a read of the memory
// word and, for an add that finds the cell clear, a write to it.
// A clear walks all ceil(MAX_BITS / 32) memory words (2048 at the default
// size), one per cycle, then reports. After reset the same pass runs with
// busy high and no result; configuration writes are taken meanwhile.
// Registers: bit_count at 0x0, hash_count at 0x4.
// Depends on bfba_pkg and bfba_seq.

module bloom_filter_bit_array
    import bfba_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 8,
    parameter int HASH_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic [31:0]           hash_0,
    input  logic [31:0]           hash_1,
    input  logic [31:0]           hash_2,
    input  logic [31:0]           hash_3,
    input  logic [31:0]           hash_4,
    input  logic [31:0]           hash_5,
    input  logic [31:0]           hash_6,
    input  logic [31:0]           hash_7,
    output logic                  done,
    output logic                  present,
    output logic [ONES_W-1:0]     ones_total
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int CMP_W = (CNT_W > CFG_BITS_W) ? CNT_W : CFG_BITS_W;

    logic [CFG_BITS_W-1:0]       bit_count_reg;
    logic [CFG_HASH_W-1:0]       hash_count_reg;
    logic                        cfg_write;
    logic [CMP_W-1:0]            bits_ext;
    logic [CNT_W-1:0]            eff_bits;
    logic [CFG_HASH_W-1:0]       eff_hashes;
    hash_word_t [HASH_PORTS-1:0] hash_in;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= CFG_BITS_W'(65536);
            hash_count_reg <= CFG_HASH_W'(8);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BIT_COUNT:  bit_count_reg  <= pwdata[CFG_BITS_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= pwdata[CFG_HASH_W-1:0];
                default:        bit_count_reg  <= bit_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BIT_COUNT:  prdata = APB_DATA_W'(bit_count_reg);
            REG_HASH_COUNT: prdata = APB_DATA_W'(hash_count_reg);
            default:        prdata = '0;
        endcase
    end

    // A zero bit count acts as one cell; counts above MAX_BITS saturate at the array size.
    always_comb
    begin
        bits_ext = CMP_W'(bit_count_reg);
        if (bits_ext == '0)
        begin
            eff_bits = CNT_W'(1);
        end
        else if (bits_ext > CMP_W'(MAX_BITS))
        begin
            eff_bits = CNT_W'(MAX_BITS);
        end
        else
        begin
            eff_bits = bits_ext[CNT_W-1:0];
        end
        if (hash_count_reg > CFG_HASH_W'(MAX_HASHES))
        begin
            eff_hashes = CFG_HASH_W'(MAX_HASHES);
        end
        else
        begin
            eff_hashes = hash_count_reg;
        end
    end

    assign hash_in = {hash_7, hash_6, hash_5, hash_4, hash_3, hash_2, hash_1, hash_0};

    bfba_seq #(
        .MAX_BITS   (MAX_BITS),
        .HASH_WIDTH (HASH_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .hash_in    (hash_in),
        .eff_bits   (eff_bits),
        .eff_hashes (eff_hashes),
        .busy       (busy),
        .done       (done),
        .present    (present),
        .ones_total (ones_total)
    );

endmodule

@@ src/bfba_mod.sv @@
// Shared modulo unit: restoring remainder, one dividend bit per cycle.
// Depends on bfba_pkg.

module bfba_mod
    import bfba_pkg::*;
#(
    parameter int DV_W  = 32,
    parameter int CNT_W = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DV_W-1:0]  dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DV_W + 1);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    always_comb
    begin
        trial       = {rem_reg, dvd_reg[DV_W-1]};
        diff        = trial - {1'b0, divisor};
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = STEP_W'(DV_W);
            rem_next    = '0;
            dvd_next    = dividend;
        end
        else if (active_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[CNT_W-1:0];
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ src/bfba_array.sv @@
// Filter bit memory: words of WORD_W cells, one write and one registered read port.
// Depends on bfba_pkg.

module bfba_array
    import bfba_pkg::*;
#(
    parameter int WORDS = 2048,
    parameter int AW    = 11
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bfba_seq.sv @@
// Sequencer of the Bloom filter: walks the hashes through the modulo unit and
// reads one memory word per hash, writing it back when an add finds the cell clear; also runs the clearing pass.
// Depends on bfba_pkg, bfba_mod and bfba_array.

module bfba_seq
    import bfba_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int HASH_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        func,
    input  hash_word_t [HASH_PORTS-1:0]       hash_in,
    input  logic [$clog2(MAX_BITS+1)-1:0]     eff_bits,
    input  logic [CFG_HASH_W-1:0]             eff_hashes,
    output logic                              busy,
    output logic                              done,
    output logic                              present,
    output logic [ONES_W-1:0]                 ones_total
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int DV_W  = (HASH_WIDTH < PORT_HASH_W) ? HASH_WIDTH : PORT_HASH_W;
    localparam int WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    seq_state_t          state_reg, state_next;
    logic [1:0]          func_reg, func_next;
    logic [HSEL_W-1:0]   hsel_reg, hsel_next;
    logic                present_reg, present_next;
    logic                report_reg, report_next;
    logic [ONES_W-1:0]   ones_reg, ones_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [DV_W-1:0]     hash_reg [HASH_PORTS];

    logic                accept;
    logic                mod_start;
    logic                mod_done;
    logic [CNT_W-1:0]    mod_rem;
    logic [AW+WORD_SEL_W-1:0] idx_ext;
    logic [AW-1:0]       word_addr;
    logic [WORD_SEL_W-1:0] bit_sel;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [WORD_W-1:0]   mem_rdata;
    logic                cur_bit;
    logic                last_hash;

    assign accept    = start && (state_reg == ST_IDLE);
    assign idx_ext   = (AW + WORD_SEL_W)'(mod_rem);
    assign word_addr = idx_ext[AW+WORD_SEL_W-1:WORD_SEL_W];
    assign bit_sel   = idx_ext[WORD_SEL_W-1:0];
    assign cur_bit   = mem_rdata[bit_sel];
    assign last_hash = ({1'b0, hsel_reg} + CFG_HASH_W'(1)) == eff_hashes;

    bfba_mod #(
        .DV_W  (DV_W),
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (hash_reg[hsel_reg]),
        .divisor   (eff_bits),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    bfba_array #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_array (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (word_addr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        hsel_next     = hsel_reg;
        present_next  = present_reg;
        report_next   = report_reg;
        ones_next     = ones_reg;
        clr_addr_next = clr_addr_reg;
        mod_start     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = word_addr;
        mem_wdata     = mem_rdata | (WORD_W'(1) << bit_sel);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(WORDS - 1))
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next    = func;
                    hsel_next    = '0;
                    present_next = (func == FUNC_CHECK);
                    case (func)
                        FUNC_ADD, FUNC_CHECK:
                        begin
                            state_next = (eff_hashes == '0) ? ST_DONE : ST_LOAD;
                        end
                        FUNC_CLEAR:
                        begin
                            ones_next     = '0;
                            clr_addr_next = '0;
                            report_next   = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                mod_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                hsel_next  = hsel_reg + HSEL_W'(1);
                state_next = last_hash ? ST_DONE : ST_LOAD;
                if (!cur_bit)
                begin
                    if (func_reg == FUNC_ADD)
                    begin
                        mem_we    = 1'b1;
                        ones_next = ones_reg + ONES_W'(1);
                    end
                    else
                    begin
                        present_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            func_reg     <= FUNC_ADD;
            hsel_reg     <= '0;
            present_reg  <= 1'b0;
            report_reg   <= 1'b0;
            ones_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            func_reg     <= func_next;
            hsel_reg     <= hsel_next;
            present_reg  <= present_next;
            report_reg   <= report_next;
            ones_reg     <= ones_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HASH_PORTS; i++)
            begin
                hash_reg[i] <= hash_in[i][DV_W-1:0];
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign present    = present_reg;
    assign ones_total = ones_reg;

endmodule
